[rtl/core/lltd_pkg.sv]
// Shared types and constants for the least-loaded task dispatcher.
// No dependencies; imported by every dispatcher module and the port checker.
`default_nettype none

package lltd_pkg;

	localparam int DEF_WORKERS     = 4;
	localparam int DEF_QUEUE_DEPTH = 1024;

	localparam int ACTION_W = 1;
	localparam int ID_W     = 32;
	localparam int COST_W   = 16;
	localparam int TAKER_W  = 2;
	localparam int SEL_W    = 2;
	localparam int LOAD_W   = 11;
	localparam int CNT_W    = 32;
	localparam int TASK_W   = ID_W + COST_W;

	localparam logic [ACTION_W-1:0] ACT_DISPATCH = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_TAKE     = 1'b1;

	typedef logic [ID_W-1:0]   task_id_t;
	typedef logic [COST_W-1:0] task_cost_t;

endpackage

`default_nettype wire

[rtl/core/least_loaded_task_dispatcher.sv]
// Least-loaded task dispatcher: per-worker ring queues in one task RAM.
// Dispatch: the strobe is registered as EXEC ends. Take with a pop: EXEC, then
// READ for the registered RAM read, then the strobe; failed take: as dispatch.
// One item at a time; busy drops in the strobe cycle, so a new item may be
// accepted there. No output stall. Reset clears pointers, counts and scan offset
// at once; RAM contents are left.
`default_nettype none

module least_loaded_task_dispatcher #(
	parameter int WORKERS     = lltd_pkg::DEF_WORKERS,
	parameter int QUEUE_DEPTH = lltd_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command side
	input  logic                          start,
	output logic                          busy,
	input  logic [lltd_pkg::ACTION_W-1:0] action,
	input  lltd_pkg::task_id_t            task_id,
	input  lltd_pkg::task_cost_t          task_cost,
	input  logic [lltd_pkg::TAKER_W-1:0]  taker_index,
	// result side
	output logic                          done,
	output logic                          ok,
	output logic [lltd_pkg::SEL_W-1:0]    worker_sel,
	output lltd_pkg::task_id_t            out_task_id,
	output lltd_pkg::task_cost_t          out_task_cost,
	output logic [lltd_pkg::LOAD_W-1:0]   queue_load,
	output logic [lltd_pkg::CNT_W-1:0]    done_count
);
	import lltd_pkg::*;

	localparam int WIW = $clog2(WORKERS);          // worker index bits
	localparam int PW  = $clog2(2 * QUEUE_DEPTH);  // ring pointer bits (mod 2*depth)
	localparam int SW  = $clog2(QUEUE_DEPTH);      // slot bits within one queue
	localparam int AW  = WIW + SW;                 // task RAM address: {worker, slot}

	localparam logic [PW-1:0]  PTR_LAST = PW'(2 * QUEUE_DEPTH - 1);
	localparam logic [WIW-1:0] OFF_LAST = WIW'(WORKERS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;  // pick / write, or issue the pop read
	localparam logic [1:0] ST_READ = 2'd2;  // RAM data of the popped task is valid

	// Pointer helpers. Pointers run modulo twice the depth so that a full
	// queue and an empty one differ.
	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
		logic [PW:0] px;
		px = {1'b0, p};
		if (px >= (PW+1)'(QUEUE_DEPTH)) begin
			px = px - (PW+1)'(QUEUE_DEPTH);
		end
		ptr_slot = px[SW-1:0];
	endfunction

	function automatic logic [PW-1:0] load_of(input logic [PW-1:0] h, input logic [PW-1:0] t);
		logic [PW:0] d;
		if (t >= h) begin
			d = {1'b0, t} - {1'b0, h};
		end else begin
			d = {1'b0, t} + (PW+1)'(2 * QUEUE_DEPTH) - {1'b0, h};
		end
		load_of = d[PW-1:0];
	endfunction

	// Control and queue state
	logic [1:0]       state_q;
	logic [WIW-1:0]   off_q;
	logic [PW-1:0]    head_q [WORKERS];
	logic [PW-1:0]    tail_q [WORKERS];
	logic [CNT_W-1:0] cnt_q  [WORKERS];
	logic             done_q;

	// Captured command (stage 1) and pop bookkeeping (stage 2)
	logic [ACTION_W-1:0] action_s1;
	task_id_t            id_s1;
	task_cost_t          cost_s1;
	logic [TAKER_W-1:0]  taker_s1;
	logic [PW-1:0]       qload_s2;
	logic [CNT_W-1:0]    cnt_s2;

	// Result registers
	logic             ok_q;
	logic [SEL_W-1:0] sel_q;
	task_id_t         oid_q;
	task_cost_t       ocost_q;
	logic [LOAD_W-1:0] load_q;
	logic [CNT_W-1:0] dcnt_q;

	// Datapath
	logic [PW-1:0]     load_w [WORKERS];
	logic              found;
	logic [WIW-1:0]    best;
	logic [PW-1:0]     best_load;
	logic [WIW-1:0]    tk;
	logic              tk_ok;
	logic [PW-1:0]     tk_load;
	logic              tk_has;
	logic              accept;
	logic              is_take;
	logic              wr_en;
	logic [AW-1:0]     waddr;
	logic              rd_en;
	logic [AW-1:0]     raddr;
	logic [TASK_W-1:0] rdata;

	assign accept  = start && (state_q == ST_IDLE);
	assign is_take = (action_s1 == ACT_TAKE);

	always_comb begin
		for (int w = 0; w < WORKERS; w++) begin
			load_w[w] = load_of(head_q[w], tail_q[w]);
		end
	end

	// Least-loaded pick over the rotated scan order; off_q already advanced.
	lltd_pick #(
		.WORKERS     (WORKERS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_pick (
		.load      (load_w),
		.off       (off_q),
		.found     (found),
		.best      (best),
		.best_load (best_load)
	);

	// Taker decode; a taker past the worker count is ignored.
	always_comb begin
		tk      = WIW'(taker_s1);
		tk_ok   = (int'(taker_s1) < WORKERS);
		tk_load = load_w[tk];
		tk_has  = tk_ok && (tk_load != '0);
	end

	// Write the dispatched task at the winner's tail; read the taker's head.
	assign wr_en = (state_q == ST_EXEC) && !is_take && found;
	assign waddr = {best, ptr_slot(tail_q[best])};
	assign rd_en = (state_q == ST_EXEC) && is_take && tk_has;
	assign raddr = {tk, ptr_slot(head_q[tk])};

	lltd_task_mem #(
		.AW (AW),
		.DW (TASK_W)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata ({id_s1, cost_s1}),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			off_q   <= '0;
			done_q  <= 1'b0;
			for (int w = 0; w < WORKERS; w++) begin
				head_q[w] <= '0;
				tail_q[w] <= '0;
				cnt_q[w]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
						// advance the scan start before the pick
						if (action == ACT_DISPATCH) begin
							off_q <= (off_q == OFF_LAST) ? '0 : off_q + WIW'(1);
						end
					end
				end
				ST_EXEC: begin
					if (!is_take) begin
						// all queues full: drop the task, nothing moves
						if (found) begin
							tail_q[best] <= ptr_next(tail_q[best]);
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (tk_has) begin
						head_q[tk] <= ptr_next(head_q[tk]);
						cnt_q[tk]  <= cnt_q[tk] + CNT_W'(1);
						state_q    <= ST_READ;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command capture and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			id_s1     <= task_id;
			cost_s1   <= task_cost;
			taker_s1  <= taker_index;
		end
		if (state_q == ST_EXEC) begin
			oid_q   <= '0;
			ocost_q <= '0;
			if (!is_take) begin
				ok_q   <= found;
				sel_q  <= found ? SEL_W'(best) : '0;
				load_q <= found ? LOAD_W'(best_load + PW'(1)) : '0;
				dcnt_q <= '0;
			end else begin
				// hold pop results until the RAM data arrives
				ok_q     <= 1'b0;
				sel_q    <= taker_s1;
				load_q   <= '0;
				dcnt_q   <= tk_ok ? cnt_q[tk] : '0;
				qload_s2 <= tk_load - PW'(1);
				cnt_s2   <= cnt_q[tk] + CNT_W'(1);
			end
		end else if (state_q == ST_READ) begin
			ok_q    <= 1'b1;
			sel_q   <= taker_s1;
			oid_q   <= rdata[TASK_W-1 -: ID_W];
			ocost_q <= rdata[COST_W-1:0];
			load_q  <= LOAD_W'(qload_s2);
			dcnt_q  <= cnt_s2;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign ok            = ok_q;
	assign worker_sel    = sel_q;
	assign out_task_id   = oid_q;
	assign out_task_cost = ocost_q;
	assign queue_load    = load_q;
	assign done_count    = dcnt_q;

endmodule

`default_nettype wire

[rtl/core/lltd_pick.sv]
// Least-loaded worker selection: registered-free min tree over per-worker keys.
// Depends on lltd_pkg.
`default_nettype none

module lltd_pick #(
	parameter int WORKERS     = lltd_pkg::DEF_WORKERS,
	parameter int QUEUE_DEPTH = lltd_pkg::DEF_QUEUE_DEPTH,
	localparam int WIW        = $clog2(WORKERS),
	localparam int PW         = $clog2(2 * QUEUE_DEPTH)
) (
	input  logic [PW-1:0]  load [WORKERS],
	input  logic [WIW-1:0] off,
	output logic           found,
	output logic [WIW-1:0] best,
	output logic [PW-1:0]  best_load
);
	import lltd_pkg::*;

	localparam int NP = 2 ** WIW;
	// key: full flag, load, position in scan order, worker index
	localparam int KW = 1 + PW + WIW + WIW;

	logic [KW-1:0] node [1:2*NP-1];
	logic [KW-1:0] leaf [NP];

	// Leaves: a full queue sorts behind every queue with room.
	for (genvar g = 0; g < NP; g++) begin : g_leaf
		if (g < WORKERS) begin : g_real
			logic [WIW:0] gx;
			logic [WIW:0] ox;
			logic [WIW:0] px;
			logic         full;
			assign gx   = (WIW+1)'(g);
			assign ox   = {1'b0, off};
			assign px   = (gx >= ox) ? (gx - ox) : (gx + (WIW+1)'(WORKERS) - ox);
			assign full = ({1'b0, load[g]} >= (PW+1)'(QUEUE_DEPTH));
			assign leaf[g] = {full, load[g], px[WIW-1:0], WIW'(g)};
		end else begin : g_pad
			assign leaf[g] = '1;
		end
	end

	// Keys are unique by scan position, so the smallest key is the first
	// least-loaded worker in scan order.
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			node[NP + i] = leaf[i];
		end
		for (int i = NP - 1; i >= 1; i--) begin
			node[i] = (node[2*i] <= node[2*i+1]) ? node[2*i] : node[2*i+1];
		end
	end

	assign found     = !node[1][KW-1];
	assign best_load = node[1][KW-2 -: PW];
	assign best      = node[1][WIW-1:0];

endmodule

`default_nettype wire

[rtl/core/lltd_task_mem.sv]
// Task store: synchronous RAM, one write and one read port, registered read data.
// Depends on lltd_pkg for default widths.
`default_nettype none

module lltd_task_mem #(
	parameter int AW = $clog2(lltd_pkg::DEF_WORKERS) + $clog2(lltd_pkg::DEF_QUEUE_DEPTH),
	parameter int DW = lltd_pkg::TASK_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	import lltd_pkg::*;

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/lltd_checker.sv]
// Port-level checks on the dispatcher's command and result timing.
// Depends on lltd_pkg; bound to least_loaded_task_dispatcher below.
`default_nettype none

module lltd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic                        ok,
	input wire lltd_pkg::task_id_t          out_task_id,
	input wire lltd_pkg::task_cost_t        out_task_cost,
	input wire logic [lltd_pkg::LOAD_W-1:0] queue_load
);
	import lltd_pkg::*;

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("dispatcher not busy after accepting an item");

	// the strobe comes only once the item is finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside the end of an item");

	// one result per item: the strobe is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// a failed item carries no task and no load
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (out_task_id == '0 && out_task_cost == '0 && queue_load == '0))
		else $error("failed item carries nonzero payload");

endmodule

bind least_loaded_task_dispatcher lltd_checker u_lltd_checker (.*);

`default_nettype wire

[bench/least_loaded_task_dispatcher_tb.sv]
// Self-checking bench for the least-loaded task dispatcher: directed plan and random
// commands, scored against hand-derived results or an in-bench model of the worker queues.
// Depends on lltd_pkg and the least_loaded_task_dispatcher RTL.
`default_nettype none

module least_loaded_task_dispatcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lltd_pkg::*;

	localparam int NW          = DEF_WORKERS;
	localparam int QD          = DEF_QUEUE_DEPTH;
	localparam int HALF_PERIOD = 5;

	// One command as it crosses the start/busy handshake.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		task_id_t            id;
		task_cost_t          cost;
		logic [TAKER_W-1:0]  taker;
	} command_t;

	// One result as it appears under the done strobe.
	typedef struct packed {
		logic               ok;
		logic [SEL_W-1:0]   sel;
		task_id_t           id;
		task_cost_t         cost;
		logic [LOAD_W-1:0]  load;
		logic [CNT_W-1:0]   count;
	} outcome_t;

	// Directed plan row: when fixed is set, want is the hand-derived result;
	// otherwise the row is scored against the queue model.
	typedef struct packed {
		command_t cmd;
		logic     fixed;
		outcome_t want;
	} plan_row_t;

	localparam plan_row_t DIRECTED [22] = '{
		// Takes from empty queues right after reset; ignored fields at their extremes.
		'{'{ACT_TAKE, 32'h0, 16'h0, 2'd0}, 1'b1, '{1'b0, 2'd0, 32'h0, 16'h0, 11'd0, 32'd0}},
		'{'{ACT_TAKE, 32'hFFFF_FFFF, 16'hFFFF, 2'd3}, 1'b1,
			'{1'b0, 2'd3, 32'h0, 16'h0, 11'd0, 32'd0}},
		// The scan offset advances before the scan, so the first dispatch lands on worker 1.
		'{'{ACT_DISPATCH, 32'h0, 16'h0, 2'd3}, 1'b1,
			'{1'b1, 2'd1, 32'h0, 16'h0, 11'd1, 32'd0}},
		'{'{ACT_DISPATCH, 32'hFFFF_FFFF, 16'hFFFF, 2'd0}, 1'b1,
			'{1'b1, 2'd2, 32'h0, 16'h0, 11'd1, 32'd0}},
		'{'{ACT_DISPATCH, 32'hA5A5_A5A5, 16'h5A5A, 2'd1}, 1'b1,
			'{1'b1, 2'd3, 32'h0, 16'h0, 11'd1, 32'd0}},
		'{'{ACT_DISPATCH, 32'h5A5A_5A5A, 16'hA5A5, 2'd2}, 1'b1,
			'{1'b1, 2'd0, 32'h0, 16'h0, 11'd1, 32'd0}},
		// Pop the all-zero and all-one tasks back out.
		'{'{ACT_TAKE, 32'h0, 16'h0, 2'd1}, 1'b1, '{1'b1, 2'd1, 32'h0, 16'h0, 11'd0, 32'd1}},
		'{'{ACT_TAKE, 32'h0, 16'h0, 2'd2}, 1'b1,
			'{1'b1, 2'd2, 32'hFFFF_FFFF, 16'hFFFF, 11'd0, 32'd1}},
		// Empty take still reports the unchanged processed count.
		'{'{ACT_TAKE, 32'h0, 16'h0, 2'd1}, 1'b1, '{1'b0, 2'd1, 32'h0, 16'h0, 11'd0, 32'd1}},
		// Ties and uneven loads; scored by the model from here on.
		'{'{ACT_DISPATCH, 32'h0000_0001, 16'h0001, 2'd0}, 1'b0, '0},
		'{'{ACT_DISPATCH, 32'h8000_0000, 16'h8000, 2'd1}, 1'b0, '0},
		'{'{ACT_DISPATCH, 32'h1234_5678, 16'h1234, 2'd2}, 1'b0, '0},
		'{'{ACT_DISPATCH, 32'hDEAD_BEEF, 16'hBEEF, 2'd3}, 1'b0, '0},
		'{'{ACT_DISPATCH, 32'hFFFF_FFFE, 16'h7FFF, 2'd0}, 1'b0, '0},
		'{'{ACT_TAKE, 32'hFFFF_FFFF, 16'hFFFF, 2'd3}, 1'b0, '0},
		'{'{ACT_TAKE, 32'h0, 16'h0, 2'd0}, 1'b0, '0},
		'{'{ACT_TAKE, 32'h0, 16'h0, 2'd2}, 1'b0, '0},
		'{'{ACT_TAKE, 32'h0, 16'h0, 2'd1}, 1'b0, '0},
		'{'{ACT_TAKE, 32'h0, 16'h0, 2'd0}, 1'b0, '0},
		'{'{ACT_TAKE, 32'h5555_5555, 16'h5555, 2'd3}, 1'b0, '0},
		'{'{ACT_DISPATCH, 32'h0, 16'hFFFF, 2'd0}, 1'b0, '0},
		'{'{ACT_DISPATCH, 32'hFFFF_FFFF, 16'h0, 2'd3}, 1'b0, '0}
	};

	// DUT connections; every input starts at a known value.
	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                start       = 1'b0;
	logic [ACTION_W-1:0] action      = ACT_DISPATCH;
	task_id_t            task_id     = '0;
	task_cost_t          task_cost   = '0;
	logic [TAKER_W-1:0]  taker_index = '0;
	logic                busy;
	logic                done;
	logic                ok;
	logic [SEL_W-1:0]    worker_sel;
	task_id_t            out_task_id;
	task_cost_t          out_task_cost;
	logic [LOAD_W-1:0]   queue_load;
	logic [CNT_W-1:0]    done_count;

	// Queue model: task slots, ring pointers (modulo twice the depth), processed
	// counts and the rotating scan offset.
	logic [TASK_W-1:0] slot_mem [NW*QD];
	logic [LOAD_W-1:0] head_at  [NW];
	logic [LOAD_W-1:0] tail_at  [NW];
	logic [CNT_W-1:0]  served   [NW];
	int                scan_from;

	outcome_t pending_outcomes [$];
	int       mismatches = 0;
	int       issued     = 0;
	bit       steady     = 1'b0;

	least_loaded_task_dispatcher uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.task_id       (task_id),
		.task_cost     (task_cost),
		.taker_index   (taker_index),
		.done          (done),
		.ok            (ok),
		.worker_sel    (worker_sel),
		.out_task_id   (out_task_id),
		.out_task_cost (out_task_cost),
		.queue_load    (queue_load),
		.done_count    (done_count)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#10_000_000;
		$display("least_loaded_task_dispatcher verification failed");
		$finish;
	end

	function automatic int fill_level(int w);
		int h, t;
		h = int'(head_at[w]);
		t = int'(tail_at[w]);
		return (t >= h) ? t - h : t + 2 * QD - h;
	endfunction

	function automatic logic [LOAD_W-1:0] step_ptr(logic [LOAD_W-1:0] p);
		return (int'(p) == 2 * QD - 1) ? '0 : p + LOAD_W'(1);
	endfunction

	// Apply one accepted command to the queue model and return its result.
	function automatic outcome_t apply_to_queues(command_t c);
		outcome_t r;
		int       best, best_lvl, w, lvl, i;
		bit       found;
		r = '0;
		if (c.action == ACT_DISPATCH) begin
			found    = 1'b0;
			best     = 0;
			best_lvl = 0;
			// Advance the offset first, then scan from it; strict compare keeps
			// the first worker in scan order on a tie.
			scan_from = (scan_from + 1) % NW;
			for (i = 0; i < NW; i++) begin
				w   = (scan_from + i) % NW;
				lvl = fill_level(w);
				if (lvl < QD && (!found || lvl < best_lvl)) begin
					found    = 1'b1;
					best     = w;
					best_lvl = lvl;
				end
			end
			// All queues full: drop the task and report all-zero.
			if (found) begin
				slot_mem[best * QD + int'(tail_at[best]) % QD] = {c.id, c.cost};
				tail_at[best] = step_ptr(tail_at[best]);
				r.ok   = 1'b1;
				r.sel  = SEL_W'(best);
				r.load = LOAD_W'(fill_level(best));
			end
		end else begin
			w     = int'(c.taker);
			r.sel = c.taker;
			if (w < NW) begin
				if (fill_level(w) > 0) begin
					{r.id, r.cost} = slot_mem[w * QD + int'(head_at[w]) % QD];
					head_at[w] = step_ptr(head_at[w]);
					served[w]  = served[w] + CNT_W'(1);
					r.ok   = 1'b1;
					r.load = LOAD_W'(fill_level(w));
				end
				r.count = served[w];
			end
		end
		return r;
	endfunction

	function automatic command_t random_command(bit dispatch);
		command_t c;
		c.action = dispatch ? ACT_DISPATCH : ACT_TAKE;
		c.id     = $urandom();
		c.cost   = task_cost_t'($urandom());
		c.taker  = TAKER_W'($urandom_range(0, NW - 1));
		return c;
	endfunction

	// Drive one command and hold it until accepted. Each command may follow an idle
	// gap, with occasional back-to-back stretches; start is low during a gap.
	task automatic issue(input command_t c, input logic fixed, input outcome_t want);
		int       gap;
		outcome_t modeled;
		if (issued % 32 == 0)
			steady = ($urandom_range(0, 3) == 0);
		issued++;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		action      <= c.action;
		task_id     <= c.id;
		task_cost   <= c.cost;
		taker_index <= c.taker;
		// Busy is sampled as it stood before the edge: start high and busy low
		// at an edge means the command was taken at that edge.
		do @(posedge clk); while (busy !== 1'b0);
		modeled = apply_to_queues(c);
		pending_outcomes.push_back(fixed ? want : modeled);
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Score every strobed result against the oldest expectation.
	always @(posedge clk) begin
		outcome_t want;
		if (done === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got ok=%0b sel=%0d",
					$time, ok, worker_sel);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				compare_field("ok",            64'(want.ok),    64'(ok));
				compare_field("worker_sel",    64'(want.sel),   64'(worker_sel));
				compare_field("out_task_id",   64'(want.id),    64'(out_task_id));
				compare_field("out_task_cost", 64'(want.cost),  64'(out_task_cost));
				compare_field("queue_load",    64'(want.load),  64'(queue_load));
				compare_field("done_count",    64'(want.count), 64'(done_count));
			end
		end
	end

	initial begin
		for (int w = 0; w < NW; w++) begin
			head_at[w] = '0;
			tail_at[w] = '0;
			served[w]  = '0;
		end
		scan_from = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed plan.
		for (int k = 0; k < $size(DIRECTED); k++)
			issue(DIRECTED[k].cmd, DIRECTED[k].fixed, DIRECTED[k].want);

		// Random mix of dispatches and takes.
		repeat (428)
			issue(random_command($urandom_range(0, 99) < 55), 1'b0, '0);

		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		// Wait on to catch any stray strobe.
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("least_loaded_task_dispatcher verification clean");
		else
			$display("least_loaded_task_dispatcher verification failed");
		$finish;
	end

endmodule

`default_nettype wire
